[src/q16alu_pkg.sv]
// q16alu_pkg: operation codes, Q16.16 limits and divider step types for the
// Q16.16 arithmetic unit. No dependencies.
`timescale 1ns / 1ps

package q16alu_pkg;

  typedef enum logic [2:0] {
    OP_SADD   = 3'd0,
    OP_MUL    = 3'd1,
    OP_SMUL   = 3'd2,
    OP_DIV    = 3'd3,
    OP_SDIV   = 3'd4,
    OP_LERP8  = 3'd5,
    OP_LERP16 = 3'd6,
    OP_LERP32 = 3'd7
  } op_t;

  localparam logic [31:0] FX_MIN = 32'h8000_0000;
  localparam logic [31:0] FX_MAX = 32'h7FFF_FFFF;
  localparam logic [65:0] MUL_HALF = 66'h0_0000_0000_0000_8000;

  // dividend magnitude bits, one quotient bit per pipeline step
  localparam int DIV_STEPS = 48;

  typedef struct packed {
    logic [31:0]          rem;
    logic [DIV_STEPS-1:0] num;
  } div_step_t;

  typedef struct packed {
    op_t                  op;
    logic [31:0]          res;
    logic                 sat;
    logic                 dz;
    logic                 qneg;
    logic [31:0]          den;
    logic [31:0]          rem;
    logic [DIV_STEPS-1:0] num;
  } dv_t;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic div_step_t div_step(input logic [31:0] rem,
                                         input logic [DIV_STEPS-1:0] num,
                                         input logic [31:0] den);
    logic [32:0] trial;
    logic        qbit;
    div_step_t   o;
    trial = {rem, num[DIV_STEPS-1]};
    qbit  = (trial >= {1'b0, den});
    if (qbit) begin
      trial = trial - {1'b0, den};
    end
    o.rem = trial[31:0];
    o.num = {num[DIV_STEPS-2:0], qbit};
    return o;
  endfunction

endpackage

[src/q16alu_req_if.sv]
// q16alu_req_if: request channel of the Q16.16 arithmetic unit.
// Valid/ready handshake with the request fields. No dependencies.
`timescale 1ns / 1ps

interface q16alu_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  logic [31:0]        fraction;

  modport source (output valid, output req_type, output operand_a, output operand_b,
                  output fraction, input ready);
  modport sink (input valid, input req_type, input operand_a, input operand_b,
                input fraction, output ready);
endinterface

[src/q16alu_rsp_if.sv]
// q16alu_rsp_if: result channel of the Q16.16 arithmetic unit.
// Valid/ready handshake with the result fields. No dependencies.
`timescale 1ns / 1ps

interface q16alu_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic               saturated;
  logic               divide_by_zero;

  modport source (output valid, output result, output saturated, output divide_by_zero,
                  input ready);
  modport sink (input valid, input result, input saturated, input divide_by_zero,
                output ready);
endinterface

[src/q16_fixed_point_alu.sv]
// channel  dir  handshake      payload
// req      in   valid/ready    req_type, operand_a, operand_b, fraction
// rsp      out  valid/ready    result, saturated, divide_by_zero
// cfg      in   cfg_we         cfg_wdata (round_enable)
//
// one item per cycle while the pipeline is not stalled by rsp; 3 front stages (input register,
// decode, 33x33 multiply with magnitudes), 48 restoring divider steps, one output register.
// every operation travels the full pipeline so results leave in order.
// rst is synchronous and clears all valid bits; round_enable resets to 1.
// a stage loads whenever it or any stage after it, towards rsp, is empty or rsp is taken,
// so bubbles collapse while a result waits.
// Uses q16alu_pkg, q16alu_req_if and q16alu_rsp_if.
`timescale 1ns / 1ps

module q16_fixed_point_alu
  import q16alu_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  q16alu_req_if.sink    req,
  q16alu_rsp_if.source  rsp
);

  localparam int FRONT = 3;
  localparam int NST   = FRONT + DIV_STEPS + 1;

  logic           round_en;
  logic [NST-1:0] vld;
  logic [NST-1:0] vld_next;
  logic [NST-1:0] en;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_en <= 1'b1;
    end else if (cfg_we) begin
      round_en <= cfg_wdata;
    end
  end

  // ---------------- flow control ----------------
  genvar gi;
  generate
    for (gi = 0; gi < NST; gi++) begin : g_en
      assign en[gi] = rsp.ready | ~(&vld[NST-1:gi]);
    end
  endgenerate

  assign vld_next  = {vld[NST-2:0], req.valid};
  assign req.ready = en[0];
  assign rsp.valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) begin
          vld[i] <= vld_next[i];
        end
      end
    end
  end

  // ---------------- stage 1: input register ----------------
  op_t                s1_op;
  logic signed [31:0] s1_a;
  logic signed [31:0] s1_b;
  logic [31:0]        s1_f;
  logic               s1_rnd;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_op  <= op_t'(req.req_type);
      s1_a   <= req.operand_a;
      s1_b   <= req.operand_b;
      s1_f   <= req.fraction;
      s1_rnd <= round_en;
    end
  end

  // ---------------- stage 2: decode, add, operand select ----------------
  op_t                s2_op;
  logic signed [31:0] s2_a;
  logic signed [31:0] s2_b;
  logic               s2_rnd;
  logic signed [32:0] s2_x;
  logic signed [32:0] s2_y;
  logic signed [48:0] s2_t;
  logic [31:0]        s2_res;
  logic               s2_sat;
  logic               s2_dz;

  logic signed [32:0] x_next;
  logic signed [32:0] y_next;
  logic signed [48:0] t_next;
  logic [31:0]        res2_next;
  logic               sat2_next;
  logic               dz2_next;
  logic [31:0]        sum;
  logic [31:0]        bhalf;
  logic [31:0]        wgt;

  always_comb begin
    sum       = s1_a + s1_b;
    bhalf     = s1_b >>> 1;
    res2_next = sum;
    sat2_next = 1'b0;
    dz2_next  = 1'b0;
    wgt       = s1_f;
    case (s1_op)
      OP_SADD: begin
        if (s1_a[31] && s1_b[31] && !sum[31]) begin
          res2_next = FX_MIN;
          sat2_next = 1'b1;
        end else if (!s1_a[31] && (s1_a != '0) && !s1_b[31] && (s1_b != '0) && sum[31]) begin
          res2_next = FX_MAX;
          sat2_next = 1'b1;
        end
      end
      OP_DIV, OP_SDIV: begin
        if (s1_b == '0) begin
          res2_next = s1_a[31] ? FX_MIN : FX_MAX;
          sat2_next = 1'b1;
          dz2_next  = 1'b1;
        end
      end
      OP_LERP8:  wgt = {24'h0, s1_f[7:0]};
      OP_LERP16: wgt = {16'h0, s1_f[15:0]};
      default:   wgt = s1_f;
    endcase
    // lerp is a + ((b - a) * w >>> k)
    if (s1_op == OP_MUL || s1_op == OP_SMUL) begin
      x_next = {s1_a[31], s1_a};
      y_next = {s1_b[31], s1_b};
    end else begin
      x_next = {s1_b[31], s1_b} - {s1_a[31], s1_a};
      y_next = {1'b0, wgt};
    end
    t_next = {{1{s1_a[31]}}, s1_a, 16'h0} +
             (s1_rnd ? {{17{bhalf[31]}}, bhalf} : 49'h0);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_op  <= s1_op;
      s2_a   <= s1_a;
      s2_b   <= s1_b;
      s2_rnd <= s1_rnd;
      s2_x   <= x_next;
      s2_y   <= y_next;
      s2_t   <= t_next;
      s2_res <= res2_next;
      s2_sat <= sat2_next;
      s2_dz  <= dz2_next;
    end
  end

  // ---------------- stage 3: multiply, magnitudes ----------------
  op_t                s3_op;
  logic signed [31:0] s3_a;
  logic               s3_rnd;
  logic signed [65:0] s3_prod;
  logic [DIV_STEPS-1:0] s3_tmag;
  logic [31:0]        s3_bmag;
  logic               s3_qneg;
  logic [31:0]        s3_res;
  logic               s3_sat;
  logic               s3_dz;

  logic signed [48:0] tneg;
  logic [31:0]        bneg;

  assign tneg = -s2_t;
  assign bneg = -s2_b;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_op   <= s2_op;
      s3_a    <= s2_a;
      s3_rnd  <= s2_rnd;
      s3_prod <= s2_x * s2_y;
      s3_tmag <= s2_t[48] ? tneg[DIV_STEPS-1:0] : s2_t[DIV_STEPS-1:0];
      s3_bmag <= s2_b[31] ? bneg : s2_b;
      s3_qneg <= s2_t[48] ^ s2_b[31];
      s3_res  <= s2_res;
      s3_sat  <= s2_sat;
      s3_dz   <= s2_dz;
    end
  end

  // ---------------- divider chain, first step also finishes mul/lerp ----------
  dv_t dv [DIV_STEPS];

  logic [65:0] prnd;
  logic [49:0] psh;
  logic [31:0] res4_next;
  logic        sat4_next;
  logic        povf;
  div_step_t   st0;

  always_comb begin
    prnd      = s3_prod + (s3_rnd ? MUL_HALF : 66'h0);
    psh       = prnd[65:16];
    povf      = !((&psh[49:31]) || !(|psh[49:31]));
    res4_next = s3_res;
    sat4_next = s3_sat;
    case (s3_op)
      OP_MUL: res4_next = psh[31:0];
      OP_SMUL: begin
        res4_next = psh[31:0];
        if (povf) begin
          res4_next = psh[49] ? FX_MIN : FX_MAX;
          sat4_next = 1'b1;
        end
      end
      OP_LERP8:  res4_next = s3_a + s3_prod[39:8];
      OP_LERP16: res4_next = s3_a + s3_prod[47:16];
      OP_LERP32: res4_next = s3_a + s3_prod[63:32];
      default:   res4_next = s3_res;
    endcase
    st0 = div_step(32'h0, s3_tmag, s3_bmag);
  end

  always_ff @(posedge clk) begin
    if (en[FRONT]) begin
      dv[0].op   <= s3_op;
      dv[0].res  <= res4_next;
      dv[0].sat  <= sat4_next;
      dv[0].dz   <= s3_dz;
      dv[0].qneg <= s3_qneg;
      dv[0].den  <= s3_bmag;
      dv[0].rem  <= st0.rem;
      dv[0].num  <= st0.num;
    end
  end

  generate
    for (gi = 1; gi < DIV_STEPS; gi++) begin : g_div
      div_step_t st;
      assign st = div_step(dv[gi-1].rem, dv[gi-1].num, dv[gi-1].den);
      always_ff @(posedge clk) begin
        if (en[FRONT+gi]) begin
          dv[gi].op   <= dv[gi-1].op;
          dv[gi].res  <= dv[gi-1].res;
          dv[gi].sat  <= dv[gi-1].sat;
          dv[gi].dz   <= dv[gi-1].dz;
          dv[gi].qneg <= dv[gi-1].qneg;
          dv[gi].den  <= dv[gi-1].den;
          dv[gi].rem  <= st.rem;
          dv[gi].num  <= st.num;
        end
      end
    end
  endgenerate

  // ---------------- output register ----------------
  dv_t         dl;
  logic [48:0] qmag;
  logic [48:0] qs;
  logic        qovf;
  logic [31:0] res_next;
  logic        sat_next;

  assign dl = dv[DIV_STEPS-1];

  always_comb begin
    qmag     = {1'b0, dl.num};
    qs       = dl.qneg ? -qmag : qmag;
    qovf     = !((&qs[48:31]) || !(|qs[48:31]));
    res_next = dl.res;
    sat_next = dl.sat;
    if ((dl.op == OP_DIV || dl.op == OP_SDIV) && !dl.dz) begin
      res_next = qs[31:0];
      if (dl.op == OP_SDIV && qovf) begin
        res_next = qs[48] ? FX_MIN : FX_MAX;
        sat_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      rsp.result         <= res_next;
      rsp.saturated      <= sat_next;
      rsp.divide_by_zero <= dl.dz;
    end
  end

  // ---------------- assertions ----------------
  a_dz_sat: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.divide_by_zero |-> rsp.saturated)
    else $error("zero divisor without saturated flag");

  a_dz_val: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.divide_by_zero |-> (rsp.result == FX_MIN || rsp.result == FX_MAX))
    else $error("zero divisor result not clamped");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> vld[0])
    else $error("accepted item lost at first stage");

  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready && req.ready |-> !(&vld))
    else $error("ready while pipeline full and stalled");

endmodule
